// ===== hw/rtl/rom_segment_stream_parser_defines.svh =====
// Assertion macros for the segment parser
`ifndef ROM_SEGMENT_STREAM_PARSER_DEFINES_SVH
`define ROM_SEGMENT_STREAM_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rsp_pkg.sv =====
`timescale 1ns / 1ps
package rsp_pkg;
  localparam int unsigned EnableTableBytes = 50;

  typedef enum logic [2:0] {
    KIND_WORD   = 3'd0,
    KIND_SEG_OK = 3'd1,
    KIND_MODES  = 3'd2,
    KIND_FLAG   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MAGIC  = 2'd1;
  localparam logic [1:0] ERR_COUNT  = 2'd2;
  localparam logic [1:0] ERR_CRC    = 2'd3;

  localparam logic [7:0] TAG_COMPAT = 8'd6;

  // one result word as it travels from front to back
  typedef struct packed {
    logic [2:0]  item_kind;
    logic [15:0] word_address;
    logic [15:0] word_value;
    logic [1:0]  ecs_mode;
    logic [1:0]  voice_mode;
    logic        jlp_enable;
    logic [1:0]  error_code;
  } result_t;

  // byte-wide CRC-16 CCITT update, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage

// ===== hw/rtl/rsp_front.sv =====
`timescale 1ns / 1ps
// Byte parser: one byte per cycle while in_stall is low, produces at most one result word
module rsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_data_byte,
  output logic               res_valid,
  output rsp_pkg::result_t   res_data,
  input  logic               q_full
);
  typedef enum logic [3:0] {
    PH_MAGIC, PH_COUNT, PH_COMPL, PH_SEG_START, PH_SEG_END, PH_DATA_HI,
    PH_DATA_LO, PH_CRC_HI, PH_CRC_LO, PH_SKIP, PH_TAG_HEAD, PH_TAG_EXT,
    PH_TAG_TYPE, PH_TAG_BODY, PH_TAG_CRC, PH_ERROR
  } phase_t;

  localparam logic [5:0] SkipInit = 6'(rsp_pkg::EnableTableBytes);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  seg_total_r, seg_total_nxt, seg_done_r, seg_done_nxt;
  logic [15:0] start_r, start_nxt, offset_r, offset_nxt, crc_r, crc_nxt;
  logic [16:0] left_r, left_nxt;
  logic [7:0]  held_r, held_nxt, ttype_r, ttype_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic [29:0] tlen_r, tlen_nxt, tidx_r, tidx_nxt;
  logic        take;
  logic [29:0] tidx_inc;
  logic [16:0] left_dec;
  logic [15:0] crc_upd;
  logic [1:0]  em, vm;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign tidx_inc = tidx_r + 30'd1;
  assign left_dec = left_r - 17'd1;
  assign crc_upd  = rsp_pkg::crc_byte(crc_r, in_data_byte);

  // mode decode of compatibility byte 0
  always_comb begin
    unique case (in_data_byte[7:6])
      2'b10:   em = 2'd1;
      2'b01:   em = 2'd2;
      default: em = 2'd0;
    endcase
    unique case (in_data_byte[3:2])
      2'b10:   vm = 2'd1;
      2'b01:   vm = 2'd2;
      default: vm = 2'd0;
    endcase
  end

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    seg_total_nxt = seg_total_r;
    seg_done_nxt  = seg_done_r;
    start_nxt     = start_r;
    offset_nxt    = offset_r;
    crc_nxt       = crc_r;
    left_nxt      = left_r;
    held_nxt      = held_r;
    ttype_nxt     = ttype_r;
    skip_nxt      = skip_r;
    tlen_nxt      = tlen_r;
    tidx_nxt      = tidx_r;
    res_valid     = 1'b0;
    res_data      = '0;
    if (take) begin
      if (in_cmd) begin
        phase_nxt = PH_MAGIC; seg_total_nxt = '0; seg_done_nxt = '0;
        start_nxt = '0; offset_nxt = '0; crc_nxt = 16'hFFFF; left_nxt = '0;
        held_nxt = '0; ttype_nxt = '0; skip_nxt = '0; tlen_nxt = '0;
        tidx_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_MAGIC: begin
            if (in_data_byte != 8'hA8 && in_data_byte != 8'h41 &&
                in_data_byte != 8'h61) begin
              phase_nxt = PH_ERROR;
              res_valid = 1'b1;
              res_data.item_kind  = rsp_pkg::KIND_ERROR;
              res_data.error_code = rsp_pkg::ERR_MAGIC;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            seg_total_nxt = in_data_byte;
            phase_nxt     = PH_COMPL;
          end
          PH_COMPL: begin
            if ((in_data_byte ^ 8'hFF) != seg_total_r) begin
              phase_nxt = PH_ERROR;
              res_valid = 1'b1;
              res_data.item_kind  = rsp_pkg::KIND_ERROR;
              res_data.error_code = rsp_pkg::ERR_COUNT;
            end else begin
              seg_done_nxt = '0;
              if (seg_total_r == 8'd0) begin
                skip_nxt  = SkipInit;
                phase_nxt = (SkipInit == 6'd0) ? PH_TAG_HEAD : PH_SKIP;
              end else begin
                phase_nxt = PH_SEG_START;
              end
            end
          end
          PH_SEG_START: begin
            crc_nxt   = rsp_pkg::crc_byte(16'hFFFF, in_data_byte);
            start_nxt = {in_data_byte, 8'h00};
            phase_nxt = PH_SEG_END;
          end
          PH_SEG_END: begin
            crc_nxt    = crc_upd;
            left_nxt   = {1'b0, {in_data_byte, 8'hFF} - start_r} + 17'd1;
            offset_nxt = '0;
            phase_nxt  = PH_DATA_HI;
          end
          PH_DATA_HI: begin
            crc_nxt   = crc_upd;
            held_nxt  = in_data_byte;
            phase_nxt = PH_DATA_LO;
          end
          PH_DATA_LO: begin
            crc_nxt    = crc_upd;
            res_valid  = 1'b1;
            res_data.item_kind    = rsp_pkg::KIND_WORD;
            res_data.word_address = start_r + offset_r;
            res_data.word_value   = {held_r, in_data_byte};
            offset_nxt = offset_r + 16'd1;
            left_nxt   = left_dec;
            phase_nxt  = (left_dec == 17'd0) ? PH_CRC_HI : PH_DATA_HI;
          end
          PH_CRC_HI: begin
            held_nxt  = in_data_byte;
            phase_nxt = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            res_valid = 1'b1;
            if ({held_r, in_data_byte} != crc_r) begin
              phase_nxt = PH_ERROR;
              res_data.item_kind  = rsp_pkg::KIND_ERROR;
              res_data.error_code = rsp_pkg::ERR_CRC;
            end else begin
              res_data.item_kind    = rsp_pkg::KIND_SEG_OK;
              res_data.word_address = start_r;
              seg_done_nxt = seg_done_r + 8'd1;
              if (seg_done_r + 8'd1 == seg_total_r) begin
                skip_nxt  = SkipInit;
                phase_nxt = (SkipInit == 6'd0) ? PH_TAG_HEAD : PH_SKIP;
              end else begin
                phase_nxt = PH_SEG_START;
              end
            end
          end
          PH_SKIP: begin
            skip_nxt = skip_r - 6'd1;
            if (skip_r == 6'd1) phase_nxt = PH_TAG_HEAD;
          end
          PH_TAG_HEAD: begin
            tlen_nxt  = {24'd0, in_data_byte[5:0]};
            ttype_nxt = {6'd0, in_data_byte[7:6]};
            tidx_nxt  = '0;
            phase_nxt = (in_data_byte[7:6] == 2'd0) ? PH_TAG_TYPE : PH_TAG_EXT;
          end
          PH_TAG_EXT: begin
            unique case (tidx_r[1:0])
              2'd0:    tlen_nxt = tlen_r | {16'd0, in_data_byte, 6'd0};
              2'd1:    tlen_nxt = tlen_r | {8'd0, in_data_byte, 14'd0};
              2'd2:    tlen_nxt = tlen_r | {in_data_byte, 22'd0};
              default: tlen_nxt = tlen_r;
            endcase
            tidx_nxt = tidx_inc;
            if (tidx_inc >= {22'd0, ttype_r}) begin
              tidx_nxt  = '0;
              phase_nxt = PH_TAG_TYPE;
            end
          end
          PH_TAG_TYPE: begin
            ttype_nxt = in_data_byte;
            tidx_nxt  = '0;
            phase_nxt = (tlen_r == 30'd0) ? PH_TAG_CRC : PH_TAG_BODY;
          end
          PH_TAG_BODY: begin
            if (ttype_r == rsp_pkg::TAG_COMPAT && tidx_r == 30'd0) begin
              res_valid = 1'b1;
              res_data.item_kind  = rsp_pkg::KIND_MODES;
              res_data.ecs_mode   = em;
              res_data.voice_mode = vm;
            end else if (ttype_r == rsp_pkg::TAG_COMPAT && tidx_r == 30'd3) begin
              res_valid = 1'b1;
              res_data.item_kind  = rsp_pkg::KIND_FLAG;
              res_data.jlp_enable = (in_data_byte[7:6] != 2'd0);
            end
            tidx_nxt = tidx_inc;
            if (tidx_inc == tlen_r) begin
              tidx_nxt  = '0;
              phase_nxt = PH_TAG_CRC;
            end
          end
          PH_TAG_CRC: begin
            tidx_nxt = tidx_inc;
            if (tidx_inc >= 30'd2) begin
              tidx_nxt  = '0;
              phase_nxt = PH_TAG_HEAD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; seg_total_r <= '0; seg_done_r <= '0;
      start_r <= '0; offset_r <= '0; crc_r <= 16'hFFFF; left_r <= '0;
      held_r <= '0; ttype_r <= '0; skip_r <= '0; tlen_r <= '0; tidx_r <= '0;
    end else begin
      phase_r <= phase_nxt; seg_total_r <= seg_total_nxt;
      seg_done_r <= seg_done_nxt; start_r <= start_nxt; offset_r <= offset_nxt;
      crc_r <= crc_nxt; left_r <= left_nxt; held_r <= held_nxt;
      ttype_r <= ttype_nxt; skip_r <= skip_nxt; tlen_r <= tlen_nxt;
      tidx_r <= tidx_nxt;
    end
  end
endmodule

// ===== hw/rtl/rsp_queue.sv =====
`timescale 1ns / 1ps
`include "rom_segment_stream_parser_defines.svh"
// Two-entry result queue between parser and output
module rsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rsp_pkg::result_t wr_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_pkg::result_t rd_data
);
  rsp_pkg::result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign rd_en     = out_valid && !out_stall;
  assign rd_data   = mem_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  `RSP_ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !wr_en)
  `RSP_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `RSP_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(rd_data))
endmodule

// ===== hw/rtl/rom_segment_stream_parser.sv =====
`timescale 1ns / 1ps
// channel | direction | word contents
// in_     | input     | cmd, data_byte
// out_    | output    | item_kind, address, value, modes, flag, error code
// One byte per cycle while in_stall is low; each byte yields zero or one result word.
// Results pass through a two-entry queue; out_valid is driven from the registered queue count.
// in_stall rises only while the queue is full (out side stalling).
// rst_n is synchronous; parser state returns to magic-byte expect, CRC 0xFFFF.
module rom_segment_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_item_kind,
  output logic [15:0] out_word_address,
  output logic [15:0] out_word_value,
  output logic [1:0]  out_ecs_mode,
  output logic [1:0]  out_voice_mode,
  output logic        out_jlp_enable,
  output logic [1:0]  out_error_code
);
  rsp_pkg::result_t res, q_out;
  logic res_valid, q_full;

  rsp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_data_byte,
    .res_valid, .res_data(res), .q_full
  );

  rsp_queue u_queue (
    .clk, .rst_n, .wr_en(res_valid), .wr_data(res), .full(q_full),
    .out_valid, .out_stall, .rd_data(q_out)
  );

  assign out_item_kind    = q_out.item_kind;
  assign out_word_address = q_out.word_address;
  assign out_word_value   = q_out.word_value;
  assign out_ecs_mode     = q_out.ecs_mode;
  assign out_voice_mode   = q_out.voice_mode;
  assign out_jlp_enable   = q_out.jlp_enable;
  assign out_error_code   = q_out.error_code;
endmodule
